// ----- design/binary_max_heap_queue_top_macros.svh -----
// ----------------------------------------------------------------------------
// binary max-heap queue assertion macros
// shared property forms for the heap queue checkers
// ----------------------------------------------------------------------------
`ifndef BINARY_MAX_HEAP_QUEUE_TOP_MACROS_SVH
`define BINARY_MAX_HEAP_QUEUE_TOP_MACROS_SVH

// same-cycle implication, clocked on clk, off while in reset
`define BMHQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heap queue check failed");

// next-cycle implication
`define BMHQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heap queue check failed");

`endif

// ----- design/bmhq_pkg.sv -----
// ----------------------------------------------------------------------------
// bmhq_pkg
// types, sizes and codes shared by the binary max-heap queue
// ----------------------------------------------------------------------------
package bmhq_pkg;

    localparam int CAPACITY = 256;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = ADDR_W + 2;
    localparam int KEY_W    = 32;
    localparam int PAY_W    = 16;
    localparam int OCC_W    = 9;

    localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(CAPACITY);

    typedef enum logic [0:0] {
        ACT_INSERT  = 1'b0,
        ACT_EXTRACT = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_EXTRACTED = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload_id;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        entry_t            wdata;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    typedef struct packed {
        logic [KEY_W-1:0] a;
        logic [KEY_W-1:0] b;
    } cmp_req_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_EX_ROOT,
        S_EX_LAST,
        S_EX_MOV,
        S_SD_L,
        S_SD_R,
        S_SD_PICK,
        S_SD_MOVE,
        S_FIN
    } state_t;

endpackage

// ----- design/bmhq_req_if.sv -----
// ----------------------------------------------------------------------------
// bmhq_req_if
// request channel: one word is an insert or an extract
// ----------------------------------------------------------------------------
interface bmhq_req_if
    import bmhq_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [0:0]       action;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload_id;

    modport source (output valid, output action, output key, output payload_id,
                    input ready);
    modport sink   (input valid, input action, input key, input payload_id,
                    output ready);
endinterface

// ----- design/bmhq_rsp_if.sv -----
// ----------------------------------------------------------------------------
// bmhq_rsp_if
// response channel: one word per request
// ----------------------------------------------------------------------------
interface bmhq_rsp_if
    import bmhq_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] out_key;
    logic [PAY_W-1:0] out_payload;
    logic [1:0]       status;
    logic [OCC_W-1:0] occupancy;

    modport source (output valid, output out_key, output out_payload, output status,
                    output occupancy, input ready);
    modport sink   (input valid, input out_key, input out_payload, input status,
                    input occupancy, output ready);
endinterface

// ----- design/binary_max_heap_queue_top.sv -----
// ----------------------------------------------------------------------------
// binary_max_heap_queue_top
// max-heap priority queue of key and payload id words in one RAM
// ----------------------------------------------------------------------------
// One request is handled at a time; ready drops from acceptance until the
// sequencer has finished with the heap. The heap sits in a single RAM with one
// read and one write port, and one comparator serves every comparison, so the
// time is set by that read port: an insert climbs toward the root until a
// larger parent stops it; an extract reads the root and the last entry, then
// sifts that entry down until it stops above its children or reaches a leaf,
// and ends at once when it takes the last entry. Full or empty cases go
// straight to the response. A finished response waits in an output register,
// so the next request is accepted while it is still pending.
module binary_max_heap_queue_top
    import bmhq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    bmhq_req_if.sink    req,
    bmhq_rsp_if.source  rsp
);

    ram_req_t           ram_req;
    logic [ENTRY_W-1:0] ram_rdata;
    cmp_req_t           cmp_req;
    logic               cmp_gt;

    bmhq_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata),
        .cmp_req   (cmp_req),
        .cmp_gt    (cmp_gt)
    );

    bmhq_cmp u_cmp (
        .operands (cmp_req),
        .a_gt_b   (cmp_gt)
    );

    bmhq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_heap_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

endmodule

// ----- design/bmhq_ram.sv -----
// ----------------------------------------------------------------------------
// bmhq_ram
// generic single-write, single-read RAM with registered read data
// ----------------------------------------------------------------------------
module bmhq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/bmhq_cmp.sv -----
// ----------------------------------------------------------------------------
// bmhq_cmp
// shared key comparator used by every compare step of the sift sequencer
// ----------------------------------------------------------------------------
module bmhq_cmp
    import bmhq_pkg::*;
(
    input  cmp_req_t operands,
    output logic     a_gt_b
);

    assign a_gt_b = (operands.a > operands.b);

endmodule

// ----- design/bmhq_seq.sv -----
// ----------------------------------------------------------------------------
// bmhq_seq
// heap sequencer: sift-up on insert, sift-down on extract, response register
// ----------------------------------------------------------------------------
module bmhq_seq
    import bmhq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    bmhq_req_if.sink         req,
    bmhq_rsp_if.source       rsp,
    output ram_req_t         ram_req,
    input  logic [ENTRY_W-1:0] ram_rdata,
    output cmp_req_t         cmp_req,
    input  logic             cmp_gt
);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    entry_t            mov_reg, mov_next;
    entry_t            best_reg, best_next;
    logic [ADDR_W-1:0] best_idx_reg, best_idx_next;
    logic [KEY_W-1:0]  wk_key_reg, wk_key_next;
    logic [PAY_W-1:0]  wk_pay_reg, wk_pay_next;
    status_t           wk_status_reg, wk_status_next;
    logic              rsp_valid_reg, rsp_valid_next;
    logic [KEY_W-1:0]  rsp_key_reg, rsp_key_next;
    logic [PAY_W-1:0]  rsp_pay_reg, rsp_pay_next;
    status_t           rsp_status_reg, rsp_status_next;
    logic [OCC_W-1:0]  rsp_occ_reg, rsp_occ_next;

    entry_t            rd_entry;
    logic [ADDR_W-1:0] parent_idx;
    logic [IDX_W-1:0]  left_ext;
    logic [IDX_W-1:0]  right_ext;
    logic [IDX_W-1:0]  count_ext;

    assign rd_entry   = entry_t'(ram_rdata);
    assign parent_idx = (pos_reg - ADDR_W'(1)) >> 1;
    assign left_ext   = IDX_W'({pos_reg, 1'b1});
    assign right_ext  = left_ext + IDX_W'(1);
    assign count_ext  = IDX_W'(count_reg);

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.out_key     = rsp_key_reg;
    assign rsp.out_payload = rsp_pay_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.occupancy   = rsp_occ_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        mov_reg        <= mov_next;
        best_reg       <= best_next;
        best_idx_reg   <= best_idx_next;
        wk_key_reg     <= wk_key_next;
        wk_pay_reg     <= wk_pay_next;
        wk_status_reg  <= wk_status_next;
        rsp_key_reg    <= rsp_key_next;
        rsp_pay_reg    <= rsp_pay_next;
        rsp_status_reg <= rsp_status_next;
        rsp_occ_reg    <= rsp_occ_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        mov_next        = mov_reg;
        best_next       = best_reg;
        best_idx_next   = best_idx_reg;
        wk_key_next     = wk_key_reg;
        wk_pay_next     = wk_pay_reg;
        wk_status_next  = wk_status_reg;
        rsp_key_next    = rsp_key_reg;
        rsp_pay_next    = rsp_pay_reg;
        rsp_status_next = rsp_status_reg;
        rsp_occ_next    = rsp_occ_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;

        req.ready       = 1'b0;
        ram_req.we      = 1'b0;
        ram_req.waddr   = pos_reg;
        ram_req.wdata   = mov_reg;
        ram_req.raddr   = '0;
        cmp_req.a       = rd_entry.key;
        cmp_req.b       = mov_reg.key;

        unique case (state_reg)
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    wk_key_next = '0;
                    wk_pay_next = '0;
                    if (req.action == ACT_INSERT)
                    begin
                        if (count_reg == CNT_W'(CAPACITY))
                        begin
                            wk_status_next = ST_FULL;
                            state_next     = S_FIN;
                        end
                        else
                        begin
                            wk_status_next = ST_INSERTED;
                            mov_next       = '{key: req.key, payload_id: req.payload_id};
                            pos_next       = count_reg[ADDR_W-1:0];
                            count_next     = count_reg + CNT_W'(1);
                            state_next     = S_UP_RD;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            wk_status_next = ST_EMPTY;
                            state_next     = S_FIN;
                        end
                        else
                        begin
                            wk_status_next = ST_EXTRACTED;
                            count_next     = count_reg - CNT_W'(1);
                            state_next     = S_EX_ROOT;
                        end
                    end
                end
            end

            // hole walks up; parent moves down while its key is not above
            S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    ram_req.we = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    ram_req.raddr = parent_idx;
                    state_next    = S_UP_CMP;
                end
            end

            S_UP_CMP:
            begin
                cmp_req.a = rd_entry.key;
                cmp_req.b = mov_reg.key;
                ram_req.we = 1'b1;
                if (!cmp_gt)
                begin
                    ram_req.wdata = rd_entry;
                    pos_next      = parent_idx;
                    state_next    = S_UP_RD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            S_EX_ROOT:
            begin
                ram_req.raddr = '0;
                state_next    = S_EX_LAST;
            end

            S_EX_LAST:
            begin
                wk_key_next   = rd_entry.key;
                wk_pay_next   = rd_entry.payload_id;
                ram_req.raddr = count_reg[ADDR_W-1:0];
                state_next    = S_EX_MOV;
            end

            S_EX_MOV:
            begin
                mov_next = rd_entry;
                pos_next = '0;
                if (count_reg == '0)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_SD_L;
                end
            end

            // hole walks down; larger child moves up while it beats the last word
            S_SD_L:
            begin
                if (left_ext >= count_ext)
                begin
                    ram_req.we = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    ram_req.raddr = left_ext[ADDR_W-1:0];
                    state_next    = S_SD_R;
                end
            end

            S_SD_R:
            begin
                best_next     = rd_entry;
                best_idx_next = left_ext[ADDR_W-1:0];
                if (right_ext < count_ext)
                begin
                    ram_req.raddr = right_ext[ADDR_W-1:0];
                    state_next    = S_SD_PICK;
                end
                else
                begin
                    state_next = S_SD_MOVE;
                end
            end

            S_SD_PICK:
            begin
                cmp_req.a = rd_entry.key;
                cmp_req.b = best_reg.key;
                if (cmp_gt)
                begin
                    best_next     = rd_entry;
                    best_idx_next = right_ext[ADDR_W-1:0];
                end
                state_next = S_SD_MOVE;
            end

            S_SD_MOVE:
            begin
                cmp_req.a  = best_reg.key;
                cmp_req.b  = mov_reg.key;
                ram_req.we = 1'b1;
                if (cmp_gt)
                begin
                    ram_req.wdata = best_reg;
                    pos_next      = best_idx_reg;
                    state_next    = S_SD_L;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_key_next    = wk_key_reg;
                    rsp_pay_next    = wk_pay_reg;
                    rsp_status_next = wk_status_reg;
                    rsp_occ_next    = OCC_W'(count_reg);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- design/bmhq_chk.sv -----
// ----------------------------------------------------------------------------
// bmhq_chk
// port-level checks for the heap queue, bound to the top level
// ----------------------------------------------------------------------------
`include "binary_max_heap_queue_top_macros.svh"

module bmhq_chk
    import bmhq_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_ready,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input logic [KEY_W-1:0] rsp_out_key,
    input logic [PAY_W-1:0] rsp_out_payload,
    input logic [1:0]       rsp_status,
    input logic [OCC_W-1:0] rsp_occupancy
);

    logic rsp_other;
    logic rsp_zero;

    assign rsp_other = rsp_valid && (rsp_status != ST_EXTRACTED);
    assign rsp_zero  = (rsp_out_key == '0) && (rsp_out_payload == '0);

    // an accepted word always keeps the sequencer busy, with ready low, in the next cycle
    `BMHQ_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)

    `BMHQ_ASSERT_NEXT(a_rsp_held, rsp_valid && !rsp_ready, rsp_valid)

    // only an extract returns an entry
    `BMHQ_ASSERT_NOW(a_zero_unless_extract, rsp_other, rsp_zero)

    `BMHQ_ASSERT_NOW(a_full_occupancy, rsp_valid && (rsp_status == ST_FULL), rsp_occupancy == FULL_OCC)

endmodule

bind binary_max_heap_queue_top bmhq_chk u_bmhq_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_out_key     (rsp.out_key),
    .rsp_out_payload (rsp.out_payload),
    .rsp_status      (rsp.status),
    .rsp_occupancy   (rsp.occupancy)
);
